// File: src/ipxf_pkg.sv
// ----------------------------------------------------------------------------
// ipxf_pkg
// Shared types and constants for the IPX-over-Ethernet frame filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ipxf_pkg;

    localparam int unsigned IPX_HEADER_BYTES = 30;
    localparam int unsigned MAX_8023_LENGTH  = 1500;
    localparam int unsigned MAC_HEADER_BYTES = 14;
    localparam int unsigned LLC_HEADER_BYTES = 3;

    localparam logic [15:0] IPX_ETHERTYPE  = 16'h8137;
    localparam logic [7:0]  IPX_SAP        = 8'hE0;
    localparam logic [7:0]  LLC_UI_CONTROL = 8'h03;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    // byte positions captured from the frame header
    localparam logic [15:0] POS_TYPE_HI = 16'd12;
    localparam logic [15:0] POS_TYPE_LO = 16'd13;
    localparam logic [15:0] POS_DSAP    = 16'd14;
    localparam logic [15:0] POS_CONTROL = 16'd16;

    // frame_format register codes; the unused code acts as LLC
    localparam logic [1:0] FMT_ETH2 = 2'd0;
    localparam logic [1:0] FMT_RAW  = 2'd1;
    localparam logic [1:0] FMT_LLC  = 2'd2;

    localparam logic [4:0] OFFSET_MAC = 5'(MAC_HEADER_BYTES);
    localparam logic [4:0] OFFSET_LLC = 5'(MAC_HEADER_BYTES + LLC_HEADER_BYTES);

    typedef enum logic [2:0] {
        RSN_OK        = 3'd0,
        RSN_SHORT     = 3'd1,
        RSN_ETHERTYPE = 3'd2,
        RSN_LEN_BIG   = 3'd3,
        RSN_LEN_SMALL = 3'd4,
        RSN_LEN_PAST  = 3'd5,
        RSN_DSAP      = 3'd6,
        RSN_CONTROL   = 3'd7
    } t_reason;

    // snapshot of one finished frame, handed to the verdict logic
    typedef struct packed {
        logic [1:0]  frame_format;
        logic [15:0] byte_total;
        logic [15:0] type_length;
        logic [7:0]  llc_dsap;
        logic [7:0]  llc_control;
    } t_frame_sum;

    typedef struct packed {
        logic        accepted;
        t_reason     reject_reason;
        logic [4:0]  ipx_offset;
        logic [15:0] ipx_length;
    } t_verdict;

endpackage

`default_nettype wire

// File: src/ipxf_if.sv
// ----------------------------------------------------------------------------
// ipxf_if
// Valid/ready channels: receive bytes in, frame verdicts out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipxf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ipxf_verdict_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [2:0]  reject_reason;
    logic [4:0]  ipx_offset;
    logic [15:0] ipx_length;

    modport source (output valid, output accepted, output reject_reason,
                    output ipx_offset, output ipx_length, input ready);
    modport sink   (input valid, input accepted, input reject_reason,
                    input ipx_offset, input ipx_length, output ready);
endinterface

`default_nettype wire

// File: src/ipxf_frame_track.sv
// ----------------------------------------------------------------------------
// ipxf_frame_track
// Per-frame byte counter and header capture; snapshots a frame on its last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ipxf_frame_track
    import ipxf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_take,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic [1:0]  i_frame_format,
    input  wire logic        i_advance,
    output logic             o_sum_valid,
    output t_frame_sum       o_sum
);

    logic [15:0] r_count, n_count;
    logic [15:0] r_tl, n_tl;
    logic [7:0]  r_dsap, n_dsap;
    logic [7:0]  r_ctrl, n_ctrl;
    logic        r_sum_valid;
    t_frame_sum  r_sum;

    always_comb begin
        n_tl   = r_tl;
        n_dsap = r_dsap;
        n_ctrl = r_ctrl;
        if (r_count == POS_TYPE_HI) begin
            n_tl[15:8] = i_data_byte;
        end
        if (r_count == POS_TYPE_LO) begin
            n_tl[7:0] = i_data_byte;
        end
        if (r_count == POS_DSAP) begin
            n_dsap = i_data_byte;
        end
        if (r_count == POS_CONTROL) begin
            n_ctrl = i_data_byte;
        end
        n_count = (r_count != COUNT_MAX) ? r_count + 16'd1 : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_tl    <= '0;
            r_dsap  <= '0;
            r_ctrl  <= '0;
        end else if (i_take) begin
            if (i_last_byte) begin
                r_count <= '0;
                r_tl    <= '0;
                r_dsap  <= '0;
                r_ctrl  <= '0;
            end else begin
                r_count <= n_count;
                r_tl    <= n_tl;
                r_dsap  <= n_dsap;
                r_ctrl  <= n_ctrl;
            end
        end
    end

    // snapshot stage: holds the finished frame until the verdict register takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else if (i_take && i_last_byte) begin
            r_sum_valid <= 1'b1;
        end else if (i_advance) begin
            r_sum_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_last_byte) begin
            r_sum.frame_format <= i_frame_format;
            r_sum.byte_total   <= n_count;
            r_sum.type_length  <= n_tl;
            r_sum.llc_dsap     <= n_dsap;
            r_sum.llc_control  <= n_ctrl;
        end
    end

    assign o_sum_valid = r_sum_valid;
    assign o_sum       = r_sum;

endmodule

`default_nettype wire

// File: src/ipxf_verdict.sv
// ----------------------------------------------------------------------------
// ipxf_verdict
// Checks one frame snapshot against its framing and forms the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module ipxf_verdict
    import ipxf_pkg::*;
(
    input  t_frame_sum i_sum,
    output t_verdict   o_verdict
);

    logic [15:0] after_mac_len;
    logic        eth2, raw;
    t_reason     reason;
    logic [4:0]  offset;
    logic [15:0] length;

    // only meaningful once the short-frame check has passed
    assign after_mac_len = i_sum.byte_total - 16'(MAC_HEADER_BYTES);
    assign eth2 = (i_sum.frame_format == FMT_ETH2);
    assign raw  = (i_sum.frame_format == FMT_RAW);

    always_comb begin
        reason = RSN_OK;
        offset = OFFSET_MAC;
        length = '0;
        if (eth2) begin
            if (i_sum.byte_total < 16'(MAC_HEADER_BYTES + IPX_HEADER_BYTES)) begin
                reason = RSN_SHORT;
            end else if (i_sum.type_length != IPX_ETHERTYPE) begin
                reason = RSN_ETHERTYPE;
            end else begin
                length = after_mac_len;
            end
        end else if (raw) begin
            if (i_sum.byte_total < 16'(MAC_HEADER_BYTES + IPX_HEADER_BYTES)) begin
                reason = RSN_SHORT;
            end else if (i_sum.type_length > 16'(MAX_8023_LENGTH)) begin
                reason = RSN_LEN_BIG;
            end else if (i_sum.type_length < 16'(IPX_HEADER_BYTES)) begin
                reason = RSN_LEN_SMALL;
            end else if (i_sum.type_length > after_mac_len) begin
                reason = RSN_LEN_PAST;
            end else begin
                length = i_sum.type_length;
            end
        end else begin
            offset = OFFSET_LLC;
            if (i_sum.byte_total <
                16'(MAC_HEADER_BYTES + LLC_HEADER_BYTES + IPX_HEADER_BYTES)) begin
                reason = RSN_SHORT;
            end else if (i_sum.type_length > 16'(MAX_8023_LENGTH)) begin
                reason = RSN_LEN_BIG;
            end else if (i_sum.type_length < 16'(LLC_HEADER_BYTES + IPX_HEADER_BYTES)) begin
                reason = RSN_LEN_SMALL;
            end else if (i_sum.type_length > after_mac_len) begin
                reason = RSN_LEN_PAST;
            end else if (i_sum.llc_dsap != IPX_SAP) begin
                reason = RSN_DSAP;
            end else if (i_sum.llc_control != LLC_UI_CONTROL) begin
                reason = RSN_CONTROL;
            end else begin
                length = i_sum.type_length - 16'(LLC_HEADER_BYTES);
            end
        end
    end

    always_comb begin
        o_verdict.accepted      = (reason == RSN_OK);
        o_verdict.reject_reason = reason;
        o_verdict.ipx_offset    = (reason == RSN_OK) ? offset : 5'd0;
        o_verdict.ipx_length    = (reason == RSN_OK) ? length : 16'd0;
    end

endmodule

`default_nettype wire

// File: src/ipx_ethernet_frame_filter.sv
// ----------------------------------------------------------------------------
// ipx_ethernet_frame_filter
// Checks received Ethernet frames for an IPX packet in the selected framing.
// ----------------------------------------------------------------------------
//  channel     dir  handshake     payload
//  i_byte      in   valid/ready   data_byte[7:0], last_byte
//  o_verdict   out  valid/ready   accepted, reject_reason[2:0], ipx_offset[4:0],
//                                 ipx_length[15:0]
//  cfg         in   i_cfg_wr_en   i_cfg_wr_data[1:0] -> frame_format
//
//  One byte is taken per cycle while i_byte.ready is high. A last byte goes
//  through the snapshot register, then verdict logic into the output register.
//  Reset (synchronous, active low) clears the counters, the format register
//  and both valid flags. While a verdict waits, bytes keep flowing until the
//  snapshot stage also holds a frame end; ready then follows o_verdict.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ipx_ethernet_frame_filter
    import ipxf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [1:0] i_cfg_wr_data,
    ipxf_byte_if.sink       i_byte,
    ipxf_verdict_if.source  o_verdict
);

    logic [1:0] r_fmt;
    logic       take;
    logic       out_free;
    logic       sum_valid;
    t_frame_sum sum;
    t_verdict   verdict;
    logic       r_out_valid;
    t_verdict   r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_ETH2;
        end else if (i_cfg_wr_en) begin
            r_fmt <= i_cfg_wr_data;
        end
    end

    assign out_free     = !r_out_valid || o_verdict.ready;
    assign i_byte.ready = !sum_valid || out_free;
    assign take         = i_byte.valid && i_byte.ready;

    ipxf_frame_track u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_data_byte    (i_byte.data_byte),
        .i_last_byte    (i_byte.last_byte),
        .i_frame_format (r_fmt),
        .i_advance      (out_free),
        .o_sum_valid    (sum_valid),
        .o_sum          (sum)
    );

    ipxf_verdict u_verdict (
        .i_sum     (sum),
        .o_verdict (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= sum_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && sum_valid) begin
            r_out <= verdict;
        end
    end

    assign o_verdict.valid         = r_out_valid;
    assign o_verdict.accepted      = r_out.accepted;
    assign o_verdict.reject_reason = r_out.reject_reason;
    assign o_verdict.ipx_offset    = r_out.ipx_offset;
    assign o_verdict.ipx_length    = r_out.ipx_length;

`ifndef SYNTH
    // a finished frame that finds the output free must show up next cycle
    a_sum_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sum_valid && out_free) |=> r_out_valid)
        else $error("frame verdict lost between snapshot and output");

    // a new verdict only appears if a frame snapshot was waiting
    a_out_from_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> $past(sum_valid))
        else $error("verdict produced without a frame end");

    a_accept_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.accepted) |->
        (r_out.reject_reason == RSN_OK &&
         (r_out.ipx_offset == OFFSET_MAC || r_out.ipx_offset == OFFSET_LLC) &&
         r_out.ipx_length >= 16'(IPX_HEADER_BYTES)))
        else $error("accepted verdict with bad offset or length");

    a_reject_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.accepted) |->
        (r_out.reject_reason != RSN_OK && r_out.ipx_offset == 5'd0 &&
         r_out.ipx_length == 16'd0))
        else $error("rejected verdict carries packet fields");
`endif

endmodule

`default_nettype wire
